[rtl/iupm_pkg.sv]
// Shared constants, types and helper functions for the integer upscale pixel mapper.
package iupm_pkg;

    // Source frame geometry and scale limit
    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 224;
    localparam int MAX_SCALE  = 8;

    // Field widths
    localparam int SX_W       = 9;
    localparam int SY_W       = 8;
    localparam int PIX_W      = 32;
    localparam int ADDR_W     = 33;
    localparam int BASE_W     = 32;
    localparam int PITCH_W    = 16;
    localparam int DIM_W      = 13;
    localparam int BPP_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Derived internal widths
    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int CNT_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int EXT_W   = DIM_W + 1;
    localparam int SXS_W   = SX_W + SCALE_W;
    localparam int SYS_W   = SY_W + SCALE_W;
    localparam int POS_W   = DIM_W + 1;
    localparam int PROD_W  = POS_W + PITCH_W;
    localparam int COFF_W  = POS_W + 2;

    localparam logic [BPP_W-1:0] PIXEL_BITS_OK = BPP_W'(32);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS    = CFG_IDX_W'(4);

    typedef struct packed {
        logic [BASE_W-1:0]  frame_base;
        logic [PITCH_W-1:0] row_pitch;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [BPP_W-1:0]   pixel_bits;
    } t_cfg;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic offs;
        logic origin;
        logic limit;
        logic base;
        logic emit;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic enabled;
        logic empty;
        logic slot_free;
        logic last_col;
        logic last_row;
    } t_sts;

    // Largest scale whose image fits both axes; 1 when none fits
    function automatic logic [SCALE_W-1:0] calc_scale(input logic [DIM_W-1:0] sw,
                                                      input logic [DIM_W-1:0] sh);
        logic [SCALE_W-1:0] s;
        s = SCALE_W'(1);
        for (int k = 2; k <= MAX_SCALE; k++) begin
            if ({1'b0, sw} >= EXT_W'(SRC_WIDTH * k) && {1'b0, sh} >= EXT_W'(SRC_HEIGHT * k))
                s = SCALE_W'(k);
        end
        return s;
    endfunction

    // Centring offset, zero when the image overhangs the screen
    function automatic logic [DIM_W-1:0] centre_off(input logic [DIM_W-1:0] dim,
                                                    input logic [EXT_W-1:0] img);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] diff;
        ext  = {1'b0, dim};
        diff = ext - img;
        return (ext >= img) ? DIM_W'(diff >> 1) : '0;
    endfunction

endpackage

[rtl/integer_upscale_pixel_mapper.sv]
// Top level: centred nearest-neighbor integer upscaler for one source pixel per word.
//
// Each input word (src_x, src_y, pixel_value) of a 320x224 frame produces up to scale*scale
// framebuffer writes, replica rows outer and replica columns inner, with writes beyond the
// right or bottom screen edge dropped; o_last_write marks the final write of the word. The
// scale is the largest of 1..8 that fits both screen axes (1 when none fits), and the image
// is centred. With frame_base zero or pixel_bits not 32 a word is taken and yields nothing.
// Otherwise a word occupies the sequencer for its setup steps (scale and offsets, replica
// origin, clipping with the row-pitch multiply, row base), then gives one write per cycle
// while the output is not stalled.
// A single output register lets the next word be taken while the last write still waits.
// The user must write configuration only while the block is idle; the block does not enforce it.
module integer_upscale_pixel_mapper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iupm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iupm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [iupm_pkg::SX_W-1:0]           i_src_x,
    input  logic [iupm_pkg::SY_W-1:0]           i_src_y,
    input  logic [iupm_pkg::PIX_W-1:0]          i_pixel_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [iupm_pkg::ADDR_W-1:0]         o_dest_address,
    output logic [iupm_pkg::PIX_W-1:0]          o_dest_pixel,
    output logic                                o_last_write
);
    import iupm_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    iupm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iupm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iupm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_src_x        (i_src_x),
        .i_src_y        (i_src_y),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dest_address (o_dest_address),
        .o_dest_pixel   (o_dest_pixel),
        .o_last_write   (o_last_write)
    );

endmodule

[rtl/iupm_cfg.sv]
// Configuration register bank of the upscale pixel mapper.
module iupm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iupm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iupm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output iupm_pkg::t_cfg                      o_cfg
);
    import iupm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base    <= '0;
            r_cfg.row_pitch     <= PITCH_W'(2560);
            r_cfg.screen_width  <= DIM_W'(640);
            r_cfg.screen_height <= DIM_W'(480);
            r_cfg.pixel_bits    <= BPP_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_BASE:    r_cfg.frame_base    <= i_cfg_data[BASE_W-1:0];
                REG_ROW_PITCH:     r_cfg.row_pitch     <= i_cfg_data[PITCH_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[DIM_W-1:0];
                REG_PIXEL_BITS:    r_cfg.pixel_bits    <= i_cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/iupm_ctrl.sv]
// Sequencer of the upscale pixel mapper: setup steps, then one write per cycle while the output slot is free.
module iupm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  iupm_pkg::t_sts i_sts,
    output iupm_pkg::t_cmd o_cmd
);
    import iupm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OFFS   = 6'b000010,
        S_ORIGIN = 6'b000100,
        S_LIMIT  = 6'b001000,
        S_BASE   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.offs   = (r_state == S_OFFS);
        o_cmd.origin = (r_state == S_ORIGIN);
        o_cmd.limit  = (r_state == S_LIMIT);
        o_cmd.base   = (r_state == S_BASE);
        o_cmd.emit   = (r_state == S_EMIT) && i_sts.slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                // disabled output: word taken, nothing produced
                if (accept && i_sts.enabled) n_state = S_OFFS;
            end
            S_OFFS:   n_state = S_ORIGIN;
            S_ORIGIN: n_state = S_LIMIT;
            S_LIMIT:  n_state = S_BASE;
            S_BASE: begin
                n_state = i_sts.empty ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free && i_sts.last_col && i_sts.last_row) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/iupm_dp.sv]
// Datapath of the upscale pixel mapper: scale, centring, clipping and address walk.
module iupm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iupm_pkg::t_cfg                  i_cfg,
    input  iupm_pkg::t_cmd                  i_cmd,
    output iupm_pkg::t_sts                  o_sts,
    input  logic [iupm_pkg::SX_W-1:0]       i_src_x,
    input  logic [iupm_pkg::SY_W-1:0]       i_src_y,
    input  logic [iupm_pkg::PIX_W-1:0]      i_pixel_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [iupm_pkg::ADDR_W-1:0]     o_dest_address,
    output logic [iupm_pkg::PIX_W-1:0]      o_dest_pixel,
    output logic                            o_last_write
);
    import iupm_pkg::*;

    // item registers
    logic [SX_W-1:0]    r_sx;
    logic [SY_W-1:0]    r_sy;
    logic [PIX_W-1:0]   r_pix;
    logic [SCALE_W-1:0] r_scale;
    // setup results
    logic [DIM_W-1:0]   r_off_x;
    logic [DIM_W-1:0]   r_off_y;
    logic [SXS_W-1:0]   r_sx_s;
    logic [SYS_W-1:0]   r_sy_s;
    logic [POS_W-1:0]   r_row0;
    logic [POS_W-1:0]   r_col0;
    logic [PROD_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_last_dx;
    logic [CNT_W-1:0]   r_last_dy;
    logic               r_empty;
    // write walk
    logic [ADDR_W-1:0]  r_row_addr;
    logic [COFF_W-1:0]  r_col_off;
    logic [CNT_W-1:0]   r_dx;
    logic [CNT_W-1:0]   r_dy;
    // output register
    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [PIX_W-1:0]   r_o_pix;
    logic               r_o_last;

    logic [EXT_W-1:0]   img_w;
    logic [EXT_W-1:0]   img_h;
    logic [SCALE_W-1:0] ncols;
    logic [SCALE_W-1:0] nrows;
    logic [DIM_W-1:0]   rem_x;
    logic [DIM_W-1:0]   rem_y;
    logic [COFF_W-1:0]  col0_off;

    assign img_w    = EXT_W'(SRC_WIDTH) * EXT_W'(r_scale);
    assign img_h    = EXT_W'(SRC_HEIGHT) * EXT_W'(r_scale);
    assign col0_off = {r_col0, 2'b00};

    // count of on-screen replicas per axis, clipped at right and bottom edges
    always_comb begin
        rem_x = DIM_W'({1'b0, i_cfg.screen_width} - r_col0);
        rem_y = DIM_W'({1'b0, i_cfg.screen_height} - r_row0);
        if (r_col0 >= {1'b0, i_cfg.screen_width})
            ncols = '0;
        else if (rem_x < DIM_W'(r_scale))
            ncols = SCALE_W'(rem_x);
        else
            ncols = r_scale;
        if (r_row0 >= {1'b0, i_cfg.screen_height})
            nrows = '0;
        else if (rem_y < DIM_W'(r_scale))
            nrows = SCALE_W'(rem_y);
        else
            nrows = r_scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx    <= i_src_x;
            r_sy    <= i_src_y;
            r_pix   <= i_pixel_value;
            r_scale <= calc_scale(i_cfg.screen_width, i_cfg.screen_height);
        end
        if (i_cmd.offs) begin
            r_off_x <= centre_off(i_cfg.screen_width, img_w);
            r_off_y <= centre_off(i_cfg.screen_height, img_h);
            r_sx_s  <= SXS_W'(r_sx) * SXS_W'(r_scale);
            r_sy_s  <= SYS_W'(r_sy) * SYS_W'(r_scale);
        end
        if (i_cmd.origin) begin
            r_row0 <= POS_W'(r_off_y) + POS_W'(r_sy_s);
            r_col0 <= POS_W'(r_off_x) + POS_W'(r_sx_s);
        end
        if (i_cmd.limit) begin
            r_prod    <= PROD_W'(r_row0) * PROD_W'(i_cfg.row_pitch);
            r_last_dx <= CNT_W'(ncols - SCALE_W'(1));
            r_last_dy <= CNT_W'(nrows - SCALE_W'(1));
            r_empty   <= (ncols == '0) || (nrows == '0);
        end
        if (i_cmd.base) begin
            r_row_addr <= ADDR_W'(i_cfg.frame_base) + ADDR_W'(r_prod);
            r_col_off  <= col0_off;
            r_dx       <= '0;
            r_dy       <= '0;
        end else if (i_cmd.emit) begin
            if (o_sts.last_col) begin
                // next replica row
                r_dx       <= '0;
                r_dy       <= r_dy + CNT_W'(1);
                r_row_addr <= r_row_addr + ADDR_W'(i_cfg.row_pitch);
                r_col_off  <= col0_off;
            end else begin
                r_dx      <= r_dx + CNT_W'(1);
                r_col_off <= r_col_off + COFF_W'(4);
            end
        end
        if (i_cmd.emit) begin
            r_o_addr <= r_row_addr + ADDR_W'(r_col_off);
            r_o_pix  <= r_pix;
            r_o_last <= o_sts.last_col && o_sts.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.enabled   = (i_cfg.frame_base != '0) && (i_cfg.pixel_bits == PIXEL_BITS_OK);
        o_sts.empty     = r_empty;
        o_sts.slot_free = !r_o_valid || !i_out_stall;
        o_sts.last_col  = (r_dx == r_last_dx);
        o_sts.last_row  = (r_dy == r_last_dy);
    end

    assign o_out_valid    = r_o_valid;
    assign o_dest_address = r_o_addr;
    assign o_dest_pixel   = r_o_pix;
    assign o_last_write   = r_o_last;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for integer_upscale_pixel_mapper: directed and random pixels against a local predictor.
module tb;
    import iupm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_PIXELS   = 25;
    localparam int RANDOM_PIXELS  = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } t_fb_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SX_W-1:0]       i_src_x = '0;
    logic [SY_W-1:0]       i_src_y = '0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ADDR_W-1:0]     o_dest_address;
    logic [PIX_W-1:0]      o_dest_pixel;
    logic                  o_last_write;

    t_cfg      screen_cfg;
    t_fb_write fb_writes_due[$];
    t_fb_write front_write;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    int        pixels_mapped = 0;
    bit        idle_on = 1'b1;

    integer_upscale_pixel_mapper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_x        (i_src_x),
        .i_src_y        (i_src_y),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dest_address (o_dest_address),
        .o_dest_pixel   (o_dest_pixel),
        .o_last_write   (o_last_write)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Expected framebuffer writes for one source pixel under the current screen setup.
    function automatic void replicate_pixel(input logic [SX_W-1:0] sx,
                                            input logic [SY_W-1:0] sy,
                                            input logic [PIX_W-1:0] pix);
        int unsigned scale, sw, sh, img, off_x, off_y, row, col, dy, dx;
        longint unsigned addr;
        t_fb_write held;
        bit have_held;
        have_held = 1'b0;
        if (screen_cfg.frame_base == '0 || screen_cfg.pixel_bits != PIXEL_BITS_OK) return;
        sw = 32'(screen_cfg.screen_width);
        sh = 32'(screen_cfg.screen_height);
        scale = (sw / SRC_WIDTH < sh / SRC_HEIGHT) ? sw / SRC_WIDTH : sh / SRC_HEIGHT;
        if (scale == 0) scale = 1;
        if (scale > MAX_SCALE) scale = MAX_SCALE;
        img   = SRC_WIDTH * scale;
        off_x = (sw >= img) ? (sw - img) / 2 : 0;
        img   = SRC_HEIGHT * scale;
        off_y = (sh >= img) ? (sh - img) / 2 : 0;
        for (dy = 0; dy < scale; dy++) begin
            row = off_y + sy * scale + dy;
            if (row >= sh) break;
            for (dx = 0; dx < scale; dx++) begin
                col = off_x + sx * scale + dx;
                if (col >= sw) continue;
                addr = 64'(screen_cfg.frame_base) + 64'(row) * 64'(screen_cfg.row_pitch)
                       + 64'(col) * 4;
                if (have_held) fb_writes_due.push_back(held);
                held.addr = ADDR_W'(addr);
                held.pix  = pix;
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            fb_writes_due.push_back(held);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_BASE:    screen_cfg.frame_base    = data[BASE_W-1:0];
            REG_ROW_PITCH:     screen_cfg.row_pitch     = data[PITCH_W-1:0];
            REG_SCREEN_WIDTH:  screen_cfg.screen_width  = data[DIM_W-1:0];
            REG_SCREEN_HEIGHT: screen_cfg.screen_height = data[DIM_W-1:0];
            REG_PIXEL_BITS:    screen_cfg.pixel_bits    = data[BPP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input logic [31:0] base, input logic [31:0] pitch,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [31:0] bpp);
        write_reg(REG_FRAME_BASE, base);
        write_reg(REG_ROW_PITCH, pitch);
        write_reg(REG_SCREEN_WIDTH, width);
        write_reg(REG_SCREEN_HEIGHT, height);
        write_reg(REG_PIXEL_BITS, bpp);
    endtask

    task automatic send_pixel(input logic [SX_W-1:0] sx, input logic [SY_W-1:0] sy,
                              input logic [PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_src_x       <= sx;
        i_src_y       <= sy;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_in_stall);
        replicate_pixel(sx, sy, pix);
        if (screen_cfg.frame_base != '0 && screen_cfg.pixel_bits == PIXEL_BITS_OK)
            pixels_mapped++;
    endtask

    // Block must be quiet before registers change; clipped words may still be in flight.
    task automatic drain_writes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (fb_writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        logic [SX_W-1:0] sx;
        logic [SY_W-1:0] sy;
        if ($urandom_range(0, 7) != 0) begin
            sx = SX_W'($urandom_range(0, SRC_WIDTH - 1));
            sy = SY_W'($urandom_range(0, SRC_HEIGHT - 1));
        end else begin
            sx = SX_W'($urandom_range(0, 511));
            sy = SY_W'($urandom_range(0, 255));
        end
        send_pixel(sx, sy, $urandom());
    endtask

    task automatic random_screen(input bit enabled);
        logic [31:0] base, bpp, w, h;
        int unsigned k, mode;
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
            k = $urandom_range(1, 3);
            w = SRC_WIDTH * k + $urandom_range(0, SRC_WIDTH - 1);
            h = SRC_HEIGHT * k + $urandom_range(0, SRC_HEIGHT - 1);
        end else if (mode == 7) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
        end else if (mode == 8) begin
            w = $urandom_range(0, SRC_WIDTH - 1);
            h = $urandom_range(0, SRC_HEIGHT - 1);
        end else begin
            k = $urandom_range(4, MAX_SCALE);
            w = SRC_WIDTH * k + $urandom_range(0, 100);
            h = SRC_HEIGHT * k + $urandom_range(0, 100);
        end
        base = $urandom();
        if (base == 0) base = 1;
        bpp = 32;
        if (!enabled) begin
            if ($urandom_range(0, 1) == 0) base = 0;
            else bpp = $urandom_range(0, 63) ^ 32'h20 | 32'h1;
        end
        set_screen(base, $urandom_range(0, 65535), w, h, bpp);
    endtask

    task automatic test_reset_disabled();
        // frame_base resets to zero, so nothing comes out
        send_pixel(0, 0, 32'hFFFF_FFFF);
        drain_writes();
    endtask

    task automatic test_default_geometry();
        // only the base is written: reset pitch and 640x480 give scale 2, rows offset 16
        write_reg(REG_FRAME_BASE, 32'h8000_0000);
        send_pixel(0, 0, 32'h0000_0000);
        send_pixel(319, 223, 32'hFFFF_FFFF);
        send_pixel(511, 255, 32'h1234_5678);
        send_pixel(319, 255, 32'h8765_4321);
        send_pixel(320, 0, 32'hDEAD_BEEF);
        send_pixel(0, 223, 32'hA5A5_5A5A);
        drain_writes();
    endtask

    task automatic test_output_gating();
        write_reg(REG_FRAME_BASE, 32'h0);
        send_pixel(10, 10, 32'h0F0F_0F0F);
        drain_writes();
        write_reg(REG_FRAME_BASE, 32'h0010_0000);
        write_reg(REG_PIXEL_BITS, 32'd31);
        send_pixel(5, 5, 32'hF0F0_F0F0);
        drain_writes();
        // upper bits dropped: 96 reads back as 32
        write_reg(REG_PIXEL_BITS, 32'd96);
        send_pixel(7, 3, 32'h5555_AAAA);
        drain_writes();
    endtask

    task automatic test_register_extremes();
        // scale capped at 8, address carries into bit 32
        set_screen(32'hFFFF_FFFF, 32'hFFFF, 8191, 8191, 32);
        send_pixel(319, 223, 32'hFFFF_FFFF);
        send_pixel(0, 0, 32'h0000_0001);
        drain_writes();
        set_screen(32'h4, 32'h0, 320, 224, 32);
        send_pixel(319, 223, 32'hC0DE_CAFE);
        send_pixel(511, 255, 32'h0BAD_F00D);
        drain_writes();
        // zero-size screen clips everything
        set_screen(32'h100, 32'd2560, 0, 0, 32);
        send_pixel(0, 0, 32'h1111_1111);
        drain_writes();
        // screen smaller than the source: scale 1, no centring
        set_screen(32'h2000, 32'd400, 100, 50, 32);
        send_pixel(99, 49, 32'h2222_2222);
        drain_writes();
        // partial clip at the right and bottom edges, pixel beyond the source frame
        set_screen(32'h4000, 32'd2600, 650, 461, 32);
        send_pixel(322, 227, 32'h3333_3333);
        send_pixel(320, 0, 32'h4444_4444);
        drain_writes();
        // oversized values keep their low bits; the spare index changes nothing
        write_reg(REG_SCREEN_WIDTH, 32'hFFFF_E3C0);
        write_reg(REG_SCREEN_HEIGHT, 32'h0001_0438);
        write_reg(REG_ROW_PITCH, 32'hABCD_1000);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_pixel(100, 200, 32'h6666_9999);
        drain_writes();
    endtask

    task automatic test_random_screens();
        while (pixels_mapped < RANDOM_PIXELS) begin
            random_screen($urandom_range(0, 9) != 0);
            repeat (PHASE_PIXELS) send_random_pixel();
            drain_writes();
        end
    endtask

    task automatic test_steady_tail();
        idle_on = 1'b0;
        random_screen(1'b1);
        repeat (PHASE_PIXELS) send_random_pixel();
        drain_writes();
    endtask

    initial begin
        screen_cfg.frame_base    = '0;
        screen_cfg.row_pitch     = PITCH_W'(2560);
        screen_cfg.screen_width  = DIM_W'(640);
        screen_cfg.screen_height = DIM_W'(480);
        screen_cfg.pixel_bits    = BPP_W'(32);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_disabled();
        test_default_geometry();
        test_output_gating();
        test_register_extremes();
        test_random_screens();
        test_steady_tail();
        if (fb_writes_due.size() != 0)
            report_mismatch("writes never seen", 64'(fb_writes_due.size()), 64'd0);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Output stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fb_writes_due.size() == 0) begin
                report_mismatch("unexpected write, address", 64'(o_dest_address), 64'd0);
            end else begin
                front_write = fb_writes_due.pop_front();
                if (o_dest_address !== front_write.addr)
                    report_mismatch("dest_address", 64'(o_dest_address), 64'(front_write.addr));
                if (o_dest_pixel !== front_write.pix)
                    report_mismatch("dest_pixel", 64'(o_dest_pixel), 64'(front_write.pix));
                if (o_last_write !== front_write.last)
                    report_mismatch("last_write", 64'(o_last_write), 64'(front_write.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

endmodule

[files.f]
rtl/iupm_pkg.sv
rtl/iupm_cfg.sv
rtl/iupm_ctrl.sv
rtl/iupm_dp.sv
rtl/integer_upscale_pixel_mapper.sv
verif/tb.sv
